// File: hdl/dsa_pkg.sv
// Package for the downward stack allocator: item types, status codes, request codes,
// sequencer states and sizing constants. No dependencies.
package dsa_pkg;

  localparam int unsigned StackDepth   = 64;
  localparam int unsigned PoolCount    = 2;
  localparam int unsigned HeaderBytes  = 8;
  localparam int unsigned MinAlignment = 32;
  localparam int unsigned IdxW         = $clog2(StackDepth);
  localparam int unsigned CntW         = $clog2(StackDepth + 1);
  localparam int unsigned EntryW       = 65;
  localparam int unsigned MemDepth     = 2 * StackDepth;
  localparam int unsigned MemAw        = $clog2(MemDepth);

  localparam logic [2:0] CfgPool0Top    = 3'd0;
  localparam logic [2:0] CfgPool0Bottom = 3'd1;
  localparam logic [2:0] CfgPool1Top    = 3'd2;
  localparam logic [2:0] CfgPool1Bottom = 3'd3;
  localparam logic [2:0] CfgPool1Pres   = 3'd4;

  localparam logic [1:0] ReqAlloc = 2'd0;
  localparam logic [1:0] ReqFree  = 2'd1;
  localparam logic [1:0] ReqStats = 2'd2;

  localparam logic [1:0] SelAny = 2'd2;
  localparam logic [1:0] SelBad = 2'd3;

  localparam logic [3:0] StOk       = 4'd0;
  localparam logic [3:0] StBadAlign = 4'd1;
  localparam logic [3:0] StNoMem    = 4'd2;
  localparam logic [3:0] StAbsent   = 4'd3;
  localparam logic [3:0] StBadSize  = 4'd4;
  localparam logic [3:0] StFreed    = 4'd5;
  localparam logic [3:0] StPending  = 4'd6;
  localparam logic [3:0] StUnknown  = 4'd7;
  localparam logic [3:0] StNotBlock = 4'd8;
  localparam logic [3:0] StFull     = 4'd9;
  localparam logic [3:0] StBadPool  = 4'd10;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  pool_sel;
    logic [31:0] size_bytes;
    logic [31:0] align_bytes;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] alloc_address;
    logic        pool_used;
    logic [31:0] total_bytes;
    logic [31:0] used_bytes;
    logic [31:0] free_total;
    logic [31:0] largest_live;
    logic [31:0] largest_gap;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ALLOC1, S_ALLOC2, S_FPOOL, S_FSCAN, S_FWAIT, S_FMARK,
    S_POPRD, S_POPWAIT, S_POPCHK, S_SSCAN, S_SWAIT, S_SACC, S_DONE
  } state_e;

endpackage

// File: hdl/downward_stack_allocator_unit.sv
// Top level of the downward stack allocator: sequencer, pool registers and entry RAM.
// Depends on dsa_pkg and dsa_ram.
//
// One request is taken when start_i is high and busy_o is low; busy_o stays high until the
// result shows on rsp_o for one cycle with done_o. The receiver cannot stall. An allocation
// steps through S_DECODE, S_ALLOC1, S_ALLOC2 and S_DONE. A free finds its pool, scans the
// pool's entry stack through the single RAM port, marks the block and then checks the low
// end, popping pending blocks; statistics walk the stack. Errors finish sooner.
module downward_stack_allocator_unit
  import dsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  req_t        req_i,
  output logic        busy_o,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q;
  logic [31:0] top_q [2];
  logic [31:0] bot_q [2];
  logic [31:0] lm_q [2];
  logic [CntW-1:0] cnt_q [2];
  logic pres1_q;
  logic pool_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] found_q;
  logic [31:0] mem_q, span_q, acc_q, big_q;
  logic rsp_valid_q;

  // entry RAM: {pending, span, address}
  logic              ram_we;
  logic [MemAw-1:0]  ram_addr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  logic        e_pend;
  logic [31:0] e_span, e_addr;

  assign {e_pend, e_span, e_addr} = ram_rdata;

  dsa_ram #(.Width(EntryW), .Depth(MemDepth)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  function automatic logic present(input logic p, input logic pres1,
                                   input logic [31:0] t, input logic [31:0] b,
                                   input logic [31:0] l);
    if (p && !pres1) return 1'b0;
    return !(t == '0 && b == '0 && l == '0);
  endfunction

  // alignment and pool decode
  logic [31:0] align_eff;
  logic        align_bad;
  logic        sel_p;
  logic        p_pres;
  logic        stat_pres;
  logic [31:0] cur_top, cur_bot, cur_lm;
  logic [CntW-1:0] cur_cnt;

  always_comb begin
    align_bad = 1'b0;
    align_eff = req_q.align_bytes;
    if (req_q.align_bytes == '0) begin
      align_eff = 32'(MinAlignment);
    end else if ((req_q.align_bytes & (req_q.align_bytes - 32'd1)) != '0) begin
      align_bad = 1'b1;
    end else if (req_q.align_bytes < 32'(MinAlignment)) begin
      align_eff = 32'(MinAlignment);
    end
    if (req_q.pool_sel == SelAny) begin
      sel_p = pres1_q && !((lm_q[0] - bot_q[0]) > (lm_q[1] - bot_q[1]));
    end else begin
      sel_p = req_q.pool_sel[0];
    end
    cur_top = top_q[pool_q];
    cur_bot = bot_q[pool_q];
    cur_lm  = lm_q[pool_q];
    cur_cnt = cnt_q[pool_q];
    p_pres  = present(pool_q, pres1_q, cur_top, cur_bot, cur_lm);
    stat_pres = present(req_q.pool_sel[0], pres1_q, top_q[req_q.pool_sel[0]],
                        bot_q[req_q.pool_sel[0]], lm_q[req_q.pool_sel[0]]);
  end

  logic [31:0] mem_calc;
  assign mem_calc = (cur_lm - req_q.size_bytes) & ~(align_eff - 32'd1);

  logic in_pool;
  assign in_pool = p_pres && req_q.free_address >= cur_bot && req_q.free_address < cur_top;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start_i) state_d = S_DECODE;
      S_DECODE: begin
        if (req_q.req_type == ReqAlloc) begin
          state_d = (align_bad || req_q.pool_sel == SelBad) ? S_DONE : S_ALLOC1;
        end else if (req_q.req_type == ReqFree) begin
          state_d = S_FPOOL;
        end else if (req_q.req_type == ReqStats) begin
          state_d = (req_q.pool_sel[1] || !stat_pres) ? S_DONE : S_SSCAN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ALLOC1: state_d = (!p_pres || req_q.size_bytes > cur_lm) ? S_DONE : S_ALLOC2;
      S_ALLOC2: state_d = S_DONE;
      S_FPOOL: begin
        if (in_pool) begin
          state_d = (req_q.free_address < cur_lm) ? S_DONE : S_FSCAN;
        end else if (pool_q || PoolCount < 2) begin
          state_d = S_DONE;
        end
      end
      S_FSCAN:  state_d = (idx_q == cur_cnt) ? S_FMARK : S_FWAIT;
      S_FWAIT:  state_d = S_FSCAN;
      S_FMARK:  state_d = (found_q == cur_cnt || e_pend) ? S_DONE : S_POPRD;
      S_POPWAIT: state_d = S_POPCHK;
      S_POPCHK: begin
        if (rsp_q.status != StOk) begin
          state_d = S_DONE;
        end else if (!e_pend || (e_addr - 32'(HeaderBytes)) != cur_lm || cur_cnt == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_POPRD;
        end
      end
      S_POPRD:  state_d = (cur_cnt == '0) ? S_DONE : S_POPWAIT;
      S_SSCAN:  state_d = (idx_q == cur_cnt) ? S_DONE : S_SWAIT;
      S_SWAIT:  state_d = S_SACC;
      S_SACC:   state_d = S_SSCAN;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // RAM port control
  logic [MemAw-1:0] base;
  assign base = MemAw'(pool_q) * MemAw'(StackDepth);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = base + MemAw'(idx_q[IdxW-1:0]);
    ram_wdata = {1'b0, span_q, mem_q};
    case (state_q)
      S_ALLOC2: begin
        ram_we    = (state_d == S_DONE) && rsp_q.status == StOk && cur_cnt < CntW'(StackDepth)
                    && !(span_q[0]) && !(mem_q < 32'(HeaderBytes))
                    && !(mem_q - 32'(HeaderBytes) < cur_bot);
        ram_addr  = base + MemAw'(cur_cnt[IdxW-1:0]);
      end
      // end of scan: fetch the matching entry for the mark
      S_FSCAN: if (idx_q == cur_cnt) ram_addr = base + MemAw'(found_q[IdxW-1:0]);
      S_FMARK: begin
        ram_addr  = base + MemAw'(found_q[IdxW-1:0]);
        ram_we    = found_q != cur_cnt && !e_pend;
        ram_wdata = {1'b1, e_span, e_addr};
      end
      S_POPRD, S_POPWAIT: ram_addr = base + MemAw'(cur_cnt[IdxW-1:0] - IdxW'(1));
      // hold the entry just read so it is still on the output when accumulated
      S_SWAIT: ram_addr = base + MemAw'(idx_q[IdxW-1:0] - IdxW'(1));
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pres1_q <= 1'b0;
      for (int p = 0; p < 2; p++) begin
        top_q[p] <= '0;
        bot_q[p] <= '0;
        lm_q[p]  <= '0;
        cnt_q[p] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPool0Top:    begin top_q[0] <= cfg_wdata_i; lm_q[0] <= cfg_wdata_i; cnt_q[0] <= '0; end
          CfgPool0Bottom: begin bot_q[0] <= cfg_wdata_i; lm_q[0] <= top_q[0]; cnt_q[0] <= '0; end
          CfgPool1Top:    begin top_q[1] <= cfg_wdata_i; lm_q[1] <= cfg_wdata_i; cnt_q[1] <= '0; end
          CfgPool1Bottom: begin bot_q[1] <= cfg_wdata_i; lm_q[1] <= top_q[1]; cnt_q[1] <= '0; end
          CfgPool1Pres:   pres1_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (state_q == S_ALLOC2 && ram_we) begin
        cnt_q[pool_q] <= cur_cnt + CntW'(1);
        lm_q[pool_q]  <= mem_q - 32'(HeaderBytes);
      end
      if (state_q == S_POPCHK && state_d == S_POPRD) begin
        lm_q[pool_q]  <= e_addr + e_span;
        cnt_q[pool_q] <= cur_cnt - CntW'(1);
      end
    end
  end

  // request context and result build
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        req_q   <= req_i;
        rsp_q   <= '0;
        pool_q  <= 1'b0;
        idx_q   <= '0;
        acc_q   <= '0;
        big_q   <= '0;
      end
      S_DECODE: begin
        if (req_q.req_type == ReqAlloc) begin
          if (align_bad) begin
            rsp_q.status <= StBadAlign;
          end else if (req_q.pool_sel == SelBad) begin
            rsp_q.status <= StBadPool;
          end else begin
            pool_q <= sel_p;
            rsp_q.pool_used <= sel_p;
          end
        end else if (req_q.req_type == ReqStats) begin
          if (req_q.pool_sel[1]) begin
            rsp_q.status <= StBadPool;
          end else begin
            pool_q <= req_q.pool_sel[0];
            rsp_q.pool_used <= req_q.pool_sel[0];
            if (!stat_pres) rsp_q.status <= StAbsent;
          end
        end else if (req_q.req_type != ReqFree) begin
          rsp_q.status <= StUnknown;
        end
      end
      S_ALLOC1: begin
        if (!p_pres) rsp_q.status <= StAbsent;
        else if (req_q.size_bytes > cur_lm) rsp_q.status <= StNoMem;
        mem_q  <= mem_calc;
        span_q <= cur_lm - mem_calc;
      end
      S_ALLOC2: begin
        if (mem_q < 32'(HeaderBytes) || mem_q - 32'(HeaderBytes) < cur_bot) begin
          rsp_q.status <= StNoMem;
        end else if (span_q[0]) begin
          rsp_q.status <= StBadSize;
        end else if (cur_cnt >= CntW'(StackDepth)) begin
          rsp_q.status <= StFull;
        end else begin
          rsp_q.alloc_address <= mem_q;
        end
      end
      S_FPOOL: begin
        found_q <= cur_cnt;
        if (in_pool) begin
          rsp_q.pool_used <= pool_q;
          if (req_q.free_address < cur_lm) rsp_q.status <= StFreed;
        end else if (pool_q || PoolCount < 2) begin
          rsp_q.status <= StUnknown;
        end else begin
          pool_q <= 1'b1;
        end
      end
      S_FSCAN: if (idx_q != cur_cnt) idx_q <= idx_q + CntW'(1);
      S_FWAIT: if (e_addr == req_q.free_address) found_q <= idx_q - CntW'(1);
      S_FMARK: begin
        // RAM output holds the entry at found_q, fetched at the end of the scan
        if (found_q == cur_cnt) rsp_q.status <= StNotBlock;
        else if (e_pend) rsp_q.status <= StPending;
      end
      S_SSCAN: if (idx_q != cur_cnt) idx_q <= idx_q + CntW'(1);
      S_SACC: begin
        if (e_pend) acc_q <= acc_q + 32'(HeaderBytes) + e_span;
        else if (e_span > big_q) big_q <= e_span;
      end
      S_DONE: begin
        if (rsp_q.status != StOk) begin
          rsp_q.alloc_address <= '0;
        end else if (req_q.req_type == ReqStats) begin
          rsp_q.total_bytes  <= cur_top - cur_bot;
          rsp_q.largest_gap  <= cur_lm - cur_bot;
          rsp_q.free_total   <= cur_lm - cur_bot + acc_q;
          rsp_q.used_bytes   <= cur_top - cur_bot - (cur_lm - cur_bot + acc_q);
          rsp_q.largest_live <= big_q;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_IDLE && rsp_valid_q;
  assign rsp_o  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp_valid_q <= 1'b0;
    else rsp_valid_q <= state_q == S_DONE;
  end

endmodule

// File: hdl/dsa_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module dsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: hdl/dsa_checker.sv
// Port-level checker for the downward stack allocator, bound to the top level.
// Depends on dsa_pkg.
module dsa_checker
  import dsa_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input rsp_t rsp_o
);
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted item did not raise busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held longer than one cycle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != StOk |-> rsp_o.alloc_address == '0 && rsp_o.total_bytes == '0)
    else $error("error result carries data");
endmodule

bind downward_stack_allocator_unit dsa_checker u_dsa_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .rsp_o
);

// File: tb/tb_top.sv
// Self-checking testbench for downward_stack_allocator_unit: directed table, then random
// allocate/free/statistics/unknown-type traffic over several pool settings. Depends on dsa_pkg.
`timescale 1ns / 1ps

module tb_top;
  import dsa_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  req_t        req_i = '0;
  logic        busy_o, done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CfgPool0Top;
  logic [31:0] cfg_wdata_i = '0;

  downward_stack_allocator_unit u_dut (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .rsp_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the allocator state
  logic [31:0] pool_top [2];
  logic [31:0] pool_bot [2];
  logic        second_on;
  logic [31:0] low_mark [2];
  int unsigned n_entries [2];
  logic [31:0] blk_addr [2*StackDepth];
  logic [31:0] blk_span [2*StackDepth];
  logic        blk_pend [2*StackDepth];
  logic [31:0] live_addrs [$];

  rsp_t rsp_expected_q [$];
  bit   use_typed = 1'b0;
  rsp_t typed_rsp = '0;
  int   n_fail = 0, n_items = 0, n_done = 0, n_alloc_ok = 0, n_free_ok = 0, n_full = 0;

  function automatic bit pool_live(int p);
    if (p == 1 && !second_on) return 1'b0;
    return !(pool_top[p] == 0 && pool_bot[p] == 0 && low_mark[p] == 0);
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      CfgPool0Top:    begin pool_top[0] = v; low_mark[0] = v; n_entries[0] = 0; end
      CfgPool0Bottom: begin pool_bot[0] = v; low_mark[0] = pool_top[0]; n_entries[0] = 0; end
      CfgPool1Top:    begin pool_top[1] = v; low_mark[1] = v; n_entries[1] = 0; end
      CfgPool1Bottom: begin pool_bot[1] = v; low_mark[1] = pool_top[1]; n_entries[1] = 0; end
      CfgPool1Pres:   second_on = v[0];
      default: ;
    endcase
  endfunction

  function automatic logic [3:0] alloc_block(req_t r, inout rsp_t o);
    logic [31:0] al, lm, mem, span;
    int p, b;
    al = r.align_bytes;
    if (al == 0) al = MinAlignment;
    else if ((al & (al - 1)) != 0) return StBadAlign;
    else if (al < MinAlignment) al = MinAlignment;
    if (r.pool_sel == SelBad) return StBadPool;
    if (r.pool_sel == SelAny)
      p = !second_on ? 0 : (((low_mark[0] - pool_bot[0]) > (low_mark[1] - pool_bot[1])) ? 0 : 1);
    else
      p = r.pool_sel;
    o.pool_used = p[0];
    if (!pool_live(p)) return StAbsent;
    lm = low_mark[p];
    if (r.size_bytes > lm) return StNoMem;
    mem = (lm - r.size_bytes) & ~(al - 1);
    if (mem < HeaderBytes || (mem - HeaderBytes) < pool_bot[p]) return StNoMem;
    span = lm - mem;
    if (span[0]) return StBadSize;
    if (n_entries[p] >= StackDepth) return StFull;
    b = p * StackDepth + n_entries[p];
    blk_addr[b] = mem;
    blk_span[b] = span;
    blk_pend[b] = 1'b0;
    n_entries[p]++;
    low_mark[p] = mem - HeaderBytes;
    o.alloc_address = mem;
    if (live_addrs.size() >= 64) live_addrs[$urandom_range(0, 63)] = mem;
    else live_addrs.push_back(mem);
    return StOk;
  endfunction

  function automatic logic [3:0] free_block(req_t r, inout rsp_t o);
    logic [31:0] a;
    int base, found, t;
    a = r.free_address;
    for (int p = 0; p < 2; p++) begin
      if (!pool_live(p)) continue;
      if (!(a >= pool_bot[p] && a < pool_top[p])) continue;
      o.pool_used = p[0];
      if (a < low_mark[p]) return StFreed;
      base = p * StackDepth;
      found = n_entries[p];
      for (int i = 0; i < n_entries[p]; i++)
        if (blk_addr[base + i] == a) found = i;
      if (found >= n_entries[p]) return StNotBlock;
      if (blk_pend[base + found]) return StPending;
      blk_pend[base + found] = 1'b1;
      // pop pending blocks sitting at the low end
      while (n_entries[p] > 0) begin
        t = base + n_entries[p] - 1;
        if (!blk_pend[t] || (blk_addr[t] - HeaderBytes) != low_mark[p]) break;
        low_mark[p] = blk_addr[t] + blk_span[t];
        n_entries[p]--;
      end
      return StOk;
    end
    return StUnknown;
  endfunction

  function automatic logic [3:0] pool_stats(req_t r, inout rsp_t o);
    logic [31:0] total, gap, pend, big;
    int p, base;
    if (r.pool_sel >= SelAny) return StBadPool;
    p = r.pool_sel;
    o.pool_used = p[0];
    if (!pool_live(p)) return StAbsent;
    total = pool_top[p] - pool_bot[p];
    gap = low_mark[p] - pool_bot[p];
    pend = 0;
    big = 0;
    base = p * StackDepth;
    for (int i = 0; i < n_entries[p]; i++) begin
      if (blk_pend[base + i]) pend += HeaderBytes + blk_span[base + i];
      else if (blk_span[base + i] > big) big = blk_span[base + i];
    end
    o.total_bytes  = total;
    o.used_bytes   = total - (gap + pend);
    o.free_total   = gap + pend;
    o.largest_live = big;
    o.largest_gap  = gap;
    return StOk;
  endfunction

  function automatic rsp_t predict_result(req_t r);
    rsp_t o;
    logic [3:0] st;
    o = '0;
    case (r.req_type)
      ReqAlloc: st = alloc_block(r, o);
      ReqFree:  st = free_block(r, o);
      ReqStats: st = pool_stats(r, o);
      default:  st = StUnknown;
    endcase
    if (st != StOk) begin
      o.alloc_address = '0;
      o.total_bytes = '0;
      o.used_bytes = '0;
      o.free_total = '0;
      o.largest_live = '0;
      o.largest_gap = '0;
    end else begin
      if (r.req_type == ReqAlloc) n_alloc_ok++;
      if (r.req_type == ReqFree) n_free_ok++;
    end
    o.status = st;
    return o;
  endfunction

  task automatic compare_result(rsp_t e, rsp_t g);
    bit bad;
    bad = 1'b0;
    if (g.status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, g.status); bad = 1'b1;
    end
    if (g.alloc_address !== e.alloc_address) begin
      $error("alloc_address: expected %h, got %h", e.alloc_address, g.alloc_address); bad = 1'b1;
    end
    if (g.pool_used !== e.pool_used) begin
      $error("pool_used: expected %0d, got %0d", e.pool_used, g.pool_used); bad = 1'b1;
    end
    if (g.total_bytes !== e.total_bytes) begin
      $error("total_bytes: expected %h, got %h", e.total_bytes, g.total_bytes); bad = 1'b1;
    end
    if (g.used_bytes !== e.used_bytes) begin
      $error("used_bytes: expected %h, got %h", e.used_bytes, g.used_bytes); bad = 1'b1;
    end
    if (g.free_total !== e.free_total) begin
      $error("free_total: expected %h, got %h", e.free_total, g.free_total); bad = 1'b1;
    end
    if (g.largest_live !== e.largest_live) begin
      $error("largest_live: expected %h, got %h", e.largest_live, g.largest_live); bad = 1'b1;
    end
    if (g.largest_gap !== e.largest_gap) begin
      $error("largest_gap: expected %h, got %h", e.largest_gap, g.largest_gap); bad = 1'b1;
    end
    if (bad) n_fail++;
  endtask

  // Results are checked before the item taken at the same edge is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        n_done++;
        if (rsp_o.status == StFull) n_full++;
        if (rsp_expected_q.size() == 0) begin
          $error("result with no item outstanding: status %0d", rsp_o.status);
          n_fail++;
        end else begin
          compare_result(rsp_expected_q.pop_front(), rsp_o);
        end
      end
      if (start_i && !busy_o) begin
        rsp_t pr;
        pr = predict_result(req_i);
        rsp_expected_q.push_back(use_typed ? typed_rsp : pr);
        n_items++;
      end
    end
  end

  function automatic req_t mk_req(logic [1:0] kind, logic [1:0] sel, logic [31:0] size,
                                  logic [31:0] align, logic [31:0] addr);
    req_t r;
    r.req_type = kind;
    r.pool_sel = sel;
    r.size_bytes = size;
    r.align_bytes = align;
    r.free_address = addr;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(logic [3:0] st, logic [31:0] addr, logic pool);
    rsp_t o;
    o = '0;
    o.status = st;
    o.alloc_address = addr;
    o.pool_used = pool;
    return o;
  endfunction

  bit gaps_on = 1'b1;

  task automatic send_item(req_t r, bit typed, rsp_t e);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    use_typed = typed;
    typed_rsp = e;
    req_i = r;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    start_i = 1'b0;
    use_typed = 1'b0;
  endtask

  task automatic write_pools(logic [31:0] t0, logic [31:0] b0, logic [31:0] t1,
                             logic [31:0] b1, logic pres);
    logic [31:0] vals [5];
    logic [2:0]  idxs [5];
    vals = '{t0, b0, t1, b1, {31'b0, pres}};
    idxs = '{CfgPool0Top, CfgPool0Bottom, CfgPool1Top, CfgPool1Bottom, CfgPool1Pres};
    // hold off until the block has drained
    wait (rsp_expected_q.size() == 0);
    repeat (10) @(negedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_we_i = 1'b1;
      cfg_idx_i = idxs[i];
      cfg_wdata_i = vals[i];
      apply_cfg(idxs[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
    live_addrs.delete();
  endtask

  function automatic req_t rand_item();
    int k;
    logic [1:0] sel;
    logic [31:0] size, align, addr;
    k = $urandom_range(0, 99);
    sel = ($urandom_range(0, 19) == 0) ? SelBad : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 19))
      0, 1:    size = $urandom;
      2:       size = 32'hFFFF_FFFF;
      default: size = $urandom_range(0, 300);
    endcase
    case ($urandom_range(0, 11))
      0:       align = 0;
      9:       align = $urandom;
      10:      align = 32'h1 << $urandom_range(9, 31);
      11:      align = MinAlignment;
      default: align = 32'h1 << $urandom_range(0, 8);
    endcase
    addr = $urandom;
    if (live_addrs.size() > 0 && $urandom_range(0, 9) < 8) begin
      addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
      if ($urandom_range(0, 9) == 0) addr += HeaderBytes;
    end
    if (k < 50) return mk_req(ReqAlloc, sel, size, align, addr);
    if (k < 80) return mk_req(ReqFree, 2'($urandom), size, align, addr);
    if (k < 95)
      return mk_req(ReqStats, ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                           : 2'($urandom_range(0, 1)),
                    size, align, addr);
    return mk_req(2'd3, 2'($urandom), size, align, addr);
  endfunction

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t e;
    bit   needs_pools;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic add_row(bit needs_pools, req_t r, bit typed, rsp_t e);
    dir_row_t d;
    d.r = r;
    d.typed = typed;
    d.e = e;
    d.needs_pools = needs_pools;
    dir_rows.push_back(d);
  endtask

  task automatic run_random(int n, int quiet_tail);
    for (int i = 0; i < n; i++) begin
      gaps_on = (i < n - quiet_tail);
      send_item(rand_item(), 1'b0, '0);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    bit pools_set;
    pool_top = '{0, 0};
    pool_bot = '{0, 0};
    low_mark = '{0, 0};
    n_entries = '{0, 0};
    second_on = 1'b0;

    // no pool configured yet
    add_row(0, mk_req(ReqAlloc, 2'd0, 0, 0, 0), 1, mk_rsp(StAbsent, 0, 0));
    add_row(0, mk_req(ReqAlloc, 2'd1, 16, 64, 0), 1, mk_rsp(StAbsent, 0, 1));
    add_row(0, mk_req(ReqAlloc, 2'd0, 0, 3, 0), 1, mk_rsp(StBadAlign, 0, 0));
    add_row(0, mk_req(ReqAlloc, SelBad, 0, 0, 0), 1, mk_rsp(StBadPool, 0, 0));
    add_row(0, mk_req(ReqFree, 2'd0, 0, 0, 32'h1234), 1, mk_rsp(StUnknown, 0, 0));
    add_row(0, mk_req(ReqStats, 2'd0, 0, 0, 0), 1, mk_rsp(StAbsent, 0, 0));
    add_row(0, mk_req(ReqStats, SelAny, 0, 0, 0), 1, mk_rsp(StBadPool, 0, 0));
    add_row(0, mk_req(2'd3, 2'd3, '1, '1, '1), 1, mk_rsp(StUnknown, 0, 0));
    // two pools present
    add_row(1, mk_req(ReqAlloc, 2'd0, 0, 0, 0), 1, mk_rsp(StOk, 32'h1_0000, 0));
    add_row(1, mk_req(ReqAlloc, 2'd1, 32'h100, 32'h1000, 0), 1, mk_rsp(StOk, 32'h1_F000, 1));
    add_row(1, mk_req(ReqAlloc, SelAny, 32'hFFFF_FFFF, 0, 0), 1, mk_rsp(StNoMem, 0, 0));
    add_row(1, mk_req(ReqAlloc, 2'd0, 0, 32'h8000_0000, 0), 1, mk_rsp(StNoMem, 0, 0));
    add_row(1, mk_req(ReqAlloc, 2'd1, 40, 1, 0), 0, '0);
    add_row(1, mk_req(ReqAlloc, SelAny, 100, 128, 0), 0, '0);
    add_row(1, mk_req(ReqStats, 2'd0, 0, 0, 0), 0, '0);
    add_row(1, mk_req(ReqStats, 2'd1, 0, 0, 0), 0, '0);
    add_row(1, mk_req(ReqFree, 2'd0, 0, 0, 32'h1_0000), 0, '0);
    add_row(1, mk_req(ReqFree, 2'd0, 0, 0, 32'hC000), 1, mk_rsp(StFreed, 0, 0));
    add_row(1, mk_req(ReqFree, 2'd0, 0, 0, 32'h1_F000), 0, '0);
    add_row(1, mk_req(ReqFree, 2'd0, 0, 0, 32'h1_F000), 0, '0);
    add_row(1, mk_req(ReqFree, 2'd0, 0, 0, 32'h1_F800), 0, '0);
    add_row(1, mk_req(ReqStats, 2'd1, 0, 0, 0), 0, '0);
    add_row(1, mk_req(ReqStats, SelBad, 0, 0, 0), 1, mk_rsp(StBadPool, 0, 0));

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    pools_set = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].needs_pools && !pools_set) begin
        write_pools(32'h1_0000, 32'h8000, 32'h2_0000, 32'h1_8000, 1'b1);
        pools_set = 1'b1;
      end
      send_item(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);
    end

    run_random(130, 0);
    write_pools(32'h4000, 32'h3000, 32'h6000, 32'h5000, 1'b1);      // tight pools
    run_random(120, 0);
    write_pools(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFE0, 32'hFFFF_0000, 1'b1); // extremes
    run_random(80, 0);
    write_pools(32'h2_0000, 32'h1_0000, 32'h8000, 32'h8000, 1'b0);   // second pool off
    run_random(100, 0);
    write_pools(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);                 // nothing present
    run_random(30, 0);
    write_pools(32'h4_0000, 32'h3_8000, 32'h3_0000, 32'h2_C000, 1'b1); // deep stacks
    run_random(220, 100);

    wait (rsp_expected_q.size() == 0);
    repeat (400) @(posedge clk_i);
    $display("Ran %0d items over six pool settings: %0d results, %0d allocations, %0d frees,",
             n_items, n_done, n_alloc_ok, n_free_ok);
    $display("%0d full-stack refusals, %0d mismatching results.", n_full, n_fail);
    if (n_fail == 0 && rsp_expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
hdl/dsa_pkg.sv
hdl/dsa_ram.sv
hdl/downward_stack_allocator_unit.sv
hdl/dsa_checker.sv
tb/tb_top.sv
